FILE: sv/bbc_pkg.sv
package bbc_pkg;

  // Error kinds reported with each verdict.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MISMATCH = 3'd1;
  localparam logic [2:0] ERR_EMPTY    = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Bracket kind codes as kept on the stack.
  localparam logic [1:0] KIND_PAREN  = 2'd1;
  localparam logic [1:0] KIND_SQUARE = 2'd2;
  localparam logic [1:0] KIND_CURLY  = 2'd3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_OPEN,
    OP_CLOSE,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] kind;
  } qent_t;

  typedef struct packed {
    logic [QCW-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic end_exec;
    logic empty;
    logic err_latched;
  } bstat_t;

  function automatic qent_t classify(input logic [7:0] sym, input logic end_mark);
    qent_t e;
    e.op   = OP_SKIP;
    e.kind = 2'd0;
    if (end_mark) begin
      e.op = OP_END;
    end else begin
      unique case (sym)
        CH_LPAREN:  begin e.op = OP_OPEN;  e.kind = KIND_PAREN;  end
        CH_LSQUARE: begin e.op = OP_OPEN;  e.kind = KIND_SQUARE; end
        CH_LCURLY:  begin e.op = OP_OPEN;  e.kind = KIND_CURLY;  end
        CH_RPAREN:  begin e.op = OP_CLOSE; e.kind = KIND_PAREN;  end
        CH_RSQUARE: begin e.op = OP_CLOSE; e.kind = KIND_SQUARE; end
        CH_RCURLY:  begin e.op = OP_CLOSE; e.kind = KIND_CURLY;  end
        default:    begin e.op = OP_SKIP;  e.kind = 2'd0;        end
      endcase
    end
    return e;
  endfunction

endpackage

FILE: sv/bracket_balance_checker_top.sv
// Bracket balance checker: takes one byte per beat, one beat per clock while the
// queue has room. Ordinary bytes are dropped at the front; brackets and end
// markers pass a four-entry queue to the stack engine, which does one push, pop
// or verdict per cycle (a verdict once the output is free), with the top of stack
// in a register and the rest in a memory whose read is prefetched for the entry
// under the top. A verdict passes the front register, the queue and the output
// register; input flows, even while a verdict waits, if the queue has room. The
// stack holds STACK_DEPTH brackets; an opening bracket beyond it reports overflow.
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] symbol,
  input  logic       end_marker,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       balanced,
  output logic [2:0] error_kind
);
  import bbc_pkg::*;

  logic   fr_valid;
  qent_t  fr_ent;
  logic   q_ready;
  logic   q_valid;
  qent_t  head;
  logic   pop;
  qstat_t q_stat;
  bstat_t b_stat;

  bbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .symbol     (symbol),
    .end_marker (end_marker),
    .fr_valid   (fr_valid),
    .fr_ent     (fr_ent),
    .q_ready    (q_ready)
  );

  bbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_ent   (fr_ent),
    .push_ready (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head),
    .stat       (q_stat)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .balanced   (balanced),
    .error_kind (error_kind),
    .stat       (b_stat)
  );

  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (balanced == (error_kind == ERR_NONE)))
    else $error("balanced flag disagrees with error kind");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    b_stat.end_exec |=> (b_stat.empty && !b_stat.err_latched))
    else $error("stack not cleared after end marker");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/bbc_front.sv
module bbc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    symbol,
  input  logic          end_marker,
  output logic          fr_valid,
  output bbc_pkg::qent_t fr_ent,
  input  logic          q_ready
);
  import bbc_pkg::*;

  qent_t cls;
  logic  load;

  assign cls      = classify(symbol, end_marker);
  assign in_stall = fr_valid && !q_ready;
  assign load     = in_valid && !in_stall;

  // Ordinary bytes are dropped here and never reach the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (load) begin
      fr_valid <= (cls.op != OP_SKIP);
    end else if (q_ready) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_ent <= cls;
    end
  end

endmodule

FILE: sv/bbc_queue.sv
module bbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bbc_pkg::qent_t push_ent,
  output logic           push_ready,
  input  logic           pop,
  output logic           q_valid,
  output bbc_pkg::qent_t head,
  output bbc_pkg::qstat_t stat
);
  import bbc_pkg::*;

  qent_t          slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != QCW'(QUEUE_DEPTH));
  assign q_valid    = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && q_valid;
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QAW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QAW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= QCW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= QCW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

endmodule

FILE: sv/bbc_back.sv
module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bbc_pkg::qent_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           balanced,
  output logic [2:0]     error_kind,
  output bbc_pkg::bstat_t stat
);
  import bbc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  // The top entry lives in top_kind; the memory holds the entries below it.
  // The entry just under the top is kept ready through a registered read.
  logic [1:0]    stack_mem [STACK_DEPTH];
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [1:0]    top_kind;
  logic [1:0]    top_next;
  logic [2:0]    first_err;
  logic [2:0]    err_next;
  logic [1:0]    rd_q;
  logic          byp;
  logic [1:0]    byp_q;
  logic [1:0]    under;
  logic          out_free;
  logic          exec;
  logic          push;
  logic          emit;
  logic [2:0]    verdict;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  assign under    = byp ? byp_q : rd_q;
  assign out_free = !out_valid || !out_stall;
  assign exec     = q_valid && ((head.op != OP_END) || out_free);
  assign pop      = exec;
  assign wr_addr  = AW'(level - 1'b1);

  always_comb begin
    level_next = level;
    top_next   = top_kind;
    err_next   = first_err;
    push       = 1'b0;
    emit       = 1'b0;
    verdict    = ERR_NONE;
    if (exec) begin
      unique case (head.op)
        OP_END: begin
          emit       = 1'b1;
          level_next = '0;
          err_next   = ERR_NONE;
          if (first_err != ERR_NONE) begin
            verdict = first_err;
          end else if (level != '0) begin
            verdict = ERR_UNCLOSED;
          end
        end
        OP_OPEN: begin
          if (first_err == ERR_NONE) begin
            if (level == LW'(STACK_DEPTH)) begin
              err_next = ERR_OVERFLOW;
            end else begin
              push       = 1'b1;
              level_next = LW'(level + 1'b1);
              top_next   = head.kind;
            end
          end
        end
        OP_CLOSE: begin
          if (first_err == ERR_NONE) begin
            if (level == '0) begin
              err_next = ERR_EMPTY;
            end else if (top_kind != head.kind) begin
              err_next = ERR_MISMATCH;
            end else begin
              level_next = LW'(level - 1'b1);
              top_next   = under;
            end
          end
        end
        default: begin
          level_next = level;
        end
      endcase
    end
  end

  always_comb begin
    if (level_next < LW'(2)) begin
      rd_addr = '0;
    end else begin
      rd_addr = AW'(level_next - LW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      first_err <= ERR_NONE;
      byp       <= 1'b0;
    end else begin
      level     <= level_next;
      first_err <= err_next;
      byp       <= push;
    end
  end

  always_ff @(posedge clk) begin
    top_kind <= top_next;
    byp_q    <= top_kind;
    rd_q     <= stack_mem[rd_addr];
    if (push && (level != '0)) begin
      stack_mem[wr_addr] <= top_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      balanced   <= (verdict == ERR_NONE);
      error_kind <= verdict;
    end
  end

  assign stat.end_exec    = emit;
  assign stat.empty       = (level == '0);
  assign stat.err_latched = (first_err != ERR_NONE);

endmodule
